@@ src/dwmd_pkg.sv @@
// Shared types and constants for the distinct window marker detector.
`timescale 1ns / 1ps
`default_nettype none

package dwmd_pkg;

    localparam int SYM_W        = 8;
    localparam int SYMBOLS      = 1 << SYM_W;
    localparam int POS_W        = 16;
    localparam int CFG_W        = 5;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd4;
    localparam logic [CFG_W-1:0] WINDOW_MIN   = 5'd1;
    localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;

    // Input word: one stream symbol with framing marks
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             first;
        logic             last;
    } in_word_t;

    // Output word: marker position and found flag
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } out_word_t;

    // Update of the last-seen table by the symbol leaving the compare stage
    typedef struct packed {
        logic             en;
        logic [SYM_W-1:0] symbol;
        logic             first;
        logic             last;
    } upd_t;

endpackage

`default_nettype wire

@@ src/dwmd_last_seen.sv @@
// Last-seen table: step index of each symbol's latest occurrence in the stream.
`timescale 1ns / 1ps
`default_nettype none

module dwmd_last_seen #(
    parameter int MAX_WINDOW = 16,
    parameter int TICK_W     = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // lookup issued as a word is taken in
    input  wire logic                      rd_en,
    input  wire logic [dwmd_pkg::SYM_W-1:0] rd_sym,
    // update from the word leaving the compare stage
    input  wire dwmd_pkg::upd_t            upd,
    // lookup answer for the word in the compare stage
    output logic                           seen,
    output logic [TICK_W-1:0]              gap
);

    import dwmd_pkg::*;

    localparam logic [TICK_W-1:0] AGE_LIMIT = TICK_W'(MAX_WINDOW);

    // table storage, one read port for lookups and one for the scrub sweep
    logic [TICK_W-1:0] mem [SYMBOLS];

    logic [TICK_W-1:0]  rd_data_reg;
    logic               fwd_hit_reg;
    logic [TICK_W-1:0]  fwd_pos_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic [SYMBOLS-1:0] valid_reg;
    logic [SYMBOLS-1:0] valid_next;

    logic [SYM_W-1:0]   scrub_ptr_reg;
    logic [SYM_W-1:0]   scrub_ptr_next;
    logic [SYM_W-1:0]   scrub_idx_reg;
    logic [TICK_W-1:0]  scrub_data_reg;
    logic               scrub_stale_reg;
    logic               scrub_clr;
    logic [TICK_W-1:0]  stored;
    logic [TICK_W-1:0]  scrub_age;

    // memory write and both read ports
    always_ff @(posedge clk)
    begin
        if (upd.en)
        begin
            mem[upd.symbol] <= tick_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_sym];
            fwd_pos_reg <= tick_reg;
        end
        scrub_data_reg <= mem[scrub_ptr_reg];
        scrub_idx_reg  <= scrub_ptr_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            valid_reg       <= '0;
            scrub_ptr_reg   <= '0;
            scrub_stale_reg <= 1'b1;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            tick_reg        <= tick_next;
            valid_reg       <= valid_next;
            scrub_ptr_reg   <= scrub_ptr_next;
            scrub_stale_reg <= upd.en && (upd.symbol == scrub_ptr_reg);
            if (rd_en)
            begin
                // write landing on the same entry as the read: old data was read
                fwd_hit_reg <= upd.en && (upd.symbol == rd_sym);
            end
        end
    end

    // lookup answer, with the same-edge write forwarded
    always_comb
    begin
        stored = fwd_hit_reg ? fwd_pos_reg : rd_data_reg;
        seen   = valid_reg[upd.symbol] && !upd.first;
        gap    = tick_reg - stored;
    end

    // scrub: drop entries too old to matter before the step index wraps
    always_comb
    begin
        scrub_age      = tick_reg - scrub_data_reg;
        scrub_clr      = valid_reg[scrub_idx_reg] && !scrub_stale_reg
                         && (scrub_age >= AGE_LIMIT);
        scrub_ptr_next = scrub_ptr_reg + 1'b1;
        tick_next      = upd.en ? tick_reg + 1'b1 : tick_reg;
    end

    // valid bits: scrub drop, then stream clear, then the new write wins
    always_comb
    begin
        valid_next = valid_reg;
        if (scrub_clr)
        begin
            valid_next[scrub_idx_reg] = 1'b0;
        end
        if (upd.en && (upd.first || upd.last))
        begin
            valid_next = '0;
        end
        if (upd.en && !upd.last)
        begin
            valid_next[upd.symbol] = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ src/distinct_window_marker_detector_top.sv @@
// Top level of the distinct window marker detector.
//
//  channel   direction  handshake              word
//  in        input      in_valid / in_stall    symbol, first, last
//  out       output     out_valid / out_stall  position, found
//  cfg       input      cfg_write              window_len (5 bits)
//
// One word a cycle while neither side stalls; the last-seen table is read at the
// edge that accepts a word, the compare runs in the next cycle and its result
// is loaded into the output register at the following edge unless the output stalls.
// The table is 256 entries of step indices, swept by a background scrub.
// Reset clears all control state and sets window_len to 4; no clearing pass.
// A stalled output holds the compare stage only when its word has a result.
`timescale 1ns / 1ps
`default_nettype none

module distinct_window_marker_detector_top #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [dwmd_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire dwmd_pkg::in_word_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output dwmd_pkg::out_word_t             out_data
);

    import dwmd_pkg::*;

    localparam int RUN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (RUN_W > CFG_W) ? RUN_W : CFG_W;
    localparam int TICK_W = $clog2(MAX_WINDOW + 4 * SYMBOLS);
    localparam logic [RUN_W-1:0] RUN_CAP = RUN_W'(MAX_WINDOW - 1);

    logic [CFG_W-1:0]  window_len_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    in_word_t          s1_word_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    logic              reported_reg;
    logic              reported_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_word_t         out_data_reg;

    logic              in_accept;
    logic              s1_adv;
    logic              s1_res;
    out_word_t         s1_out;
    upd_t              upd;
    logic              seen;
    logic [TICK_W-1:0] gap;

    logic [RUN_W-1:0]  base_run;
    logic [POS_W-1:0]  base_count;
    logic              base_reported;
    logic [RUN_W-1:0]  lim;
    logic [RUN_W-1:0]  cand;
    logic [RUN_W-1:0]  nrun;
    logic [CFG_W-1:0]  need;
    logic [POS_W-1:0]  cnt_new;
    logic              hit;

    // last-seen table
    dwmd_last_seen #(
        .MAX_WINDOW (MAX_WINDOW),
        .TICK_W     (TICK_W)
    ) u_last_seen (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_accept),
        .rd_sym (in_data.symbol),
        .upd    (upd),
        .seen   (seen),
        .gap    (gap)
    );

    // run length and marker decision for the word in the compare stage
    always_comb
    begin
        base_run      = s1_word_reg.first ? '0 : run_reg;
        base_count    = s1_word_reg.first ? '0 : count_reg;
        base_reported = s1_word_reg.first ? 1'b0 : reported_reg;
        lim           = (base_run > RUN_CAP) ? RUN_CAP : base_run;
        cand          = lim + 1'b1;
        if (seen && (gap < TICK_W'(cand)))
        begin
            nrun = gap[RUN_W-1:0];
        end
        else
        begin
            nrun = cand;
        end
        need    = (window_len_reg == '0) ? WINDOW_MIN : window_len_reg;
        cnt_new = (base_count == POS_MAX) ? POS_MAX : base_count + 1'b1;
        hit     = !base_reported && (CMP_W'(nrun) >= CMP_W'(need));
        s1_res  = s1_valid_reg && !base_reported && (hit || s1_word_reg.last);
        s1_out.position = hit ? cnt_new : '0;
        s1_out.found    = hit;
    end

    // handshake between stages
    always_comb
    begin
        s1_adv         = s1_valid_reg && !(s1_res && out_valid_reg && out_stall);
        in_stall       = s1_valid_reg && !s1_adv;
        in_accept      = in_valid && !in_stall;
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_adv);
        out_valid_next = (out_valid_reg && out_stall) || (s1_adv && s1_res);
        upd.en         = s1_adv;
        upd.symbol     = s1_word_reg.symbol;
        upd.first      = s1_word_reg.first;
        upd.last       = s1_word_reg.last;
    end

    // stream state after the compare stage word
    always_comb
    begin
        run_next      = run_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (s1_adv)
        begin
            if (s1_word_reg.last)
            begin
                run_next      = '0;
                count_next    = '0;
                reported_next = 1'b0;
            end
            else
            begin
                run_next      = base_reported ? base_run : nrun;
                count_next    = cnt_new;
                reported_next = base_reported || hit;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_RESET;
            s1_valid_reg   <= 1'b0;
            run_reg        <= '0;
            count_reg      <= '0;
            reported_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                window_len_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg <= in_data;
        end
        if (s1_adv && s1_res)
        begin
            out_data_reg <= s1_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the distinct window marker detector: directed and random streams, scoreboard check.
module testbench;
    import dwmd_pkg::*;

    localparam int HISTORY = 15;    // stored symbols, one short of the widest window

    // Tracks stream state and holds the markers still owed by the block
    class marker_tracker;
        logic [CFG_W-1:0] window_len;
        logic [SYM_W-1:0] recent [HISTORY];
        int               run_len;
        logic [POS_W-1:0] count;
        bit               reported;
        out_word_t        awaited[$];
        int               errors;

        function new();
            window_len = WINDOW_RESET;
            errors = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (recent[i])
                recent[i] = '0;
            run_len = 0;
            count = '0;
            reported = 1'b0;
        endfunction

        // longest all-distinct run ending at the new symbol
        function void shift_in(logic [SYM_W-1:0] s);
            int lim;
            int nrun;
            lim = (run_len > HISTORY) ? HISTORY : run_len;
            nrun = lim + 1;
            // scan downwards so the nearest repeat wins
            for (int i = lim - 1; i >= 0; i--)
                if (recent[i] == s)
                    nrun = i + 1;
            for (int i = HISTORY - 1; i > 0; i--)
                recent[i] = recent[i - 1];
            recent[0] = s;
            run_len = nrun;
        endfunction

        function void note_word(in_word_t w);
            int        need;
            out_word_t r;
            need = (window_len == 0) ? 1 : int'(window_len);
            if (w.first)
                clear_stream();
            if (count != POS_MAX)
                count++;
            if (!reported)
            begin
                shift_in(w.symbol);
                if (run_len >= need)
                begin
                    r.position = count;
                    r.found = 1'b1;
                    awaited.push_back(r);
                    reported = 1'b1;
                end
                else if (w.last)
                begin
                    r.position = '0;
                    r.found = 1'b0;
                    awaited.push_back(r);
                end
            end
            if (w.last)
                clear_stream();
        endfunction

        function void check_marker(out_word_t got);
            out_word_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual position=%0d found=%0b",
                         $time, got.position, got.found);
                errors++;
            end
            else
            begin
                want = awaited.pop_front();
                if (got.position !== want.position)
                begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, got.position);
                    errors++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, got.found);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_data;

    marker_tracker tracker = new();
    bit            quiet = 1'b0;        // no idling on either side
    int            hold_request = 0;    // receiver hold-off length in cycles
    int            words_sent = 0;

    distinct_window_marker_detector_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 29);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_marker(out_data);
    end

    task automatic idle_gap();
        while (!quiet && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer one word and wait for it to be taken
    task automatic send_word(logic [SYM_W-1:0] sym, logic fst, logic lst);
        in_word_t w;
        w.symbol = sym;
        w.first = fst;
        w.last = lst;
        idle_gap();
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_word(w);
        words_sent++;
    endtask

    // Stop sending until every owed marker is out, then let the pipe empty
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_window(logic [CFG_W-1:0] v);
        drain();
        cfg_data <= v;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.window_len = v;
    endtask

    // One stream drawn from an alphabet of alph symbols, with the odd stray restart
    task automatic send_stream(int len, int alph, bit open_first, bit close_last);
        int               base;
        logic [SYM_W-1:0] sym;
        logic             fst;
        logic             lst;
        base = $urandom_range(0, 255);
        for (int k = 0; k < len; k++)
        begin
            sym = SYM_W'(base + $urandom_range(0, alph - 1));
            fst = (k == 0) ? open_first : ($urandom_range(0, 99) < 2);
            lst = (k == len - 1) ? close_last : 1'b0;
            send_word(sym, fst, lst);
        end
    endtask

    task automatic random_phase(logic [CFG_W-1:0] win, int n_words, bit hold);
        int stop;
        int roll;
        int alph;
        int len;
        set_window(win);
        if (hold)
            hold_request = 80;
        stop = words_sent + n_words;
        while (words_sent < stop)
        begin
            roll = $urandom_range(0, 99);
            alph = (roll < 15) ? 256 : $urandom_range(2, 24);
            len = (roll % 7 == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            send_stream(len, alph, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 90);
        end
    endtask

    // Main sequence
    initial
    begin
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset window of four
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b0);
        send_word(8'h7F, 1'b0, 1'b0);       // marker at 4
        send_word(8'h01, 1'b0, 1'b1);       // after the report: silent
        send_word(8'h11, 1'b1, 1'b0);
        send_word(8'h11, 1'b0, 1'b0);
        send_word(8'h22, 1'b0, 1'b1);       // stream shorter than window
        send_word(8'hA5, 1'b1, 1'b1);       // one-word stream
        send_word(8'h0A, 1'b0, 1'b0);       // new stream without first
        send_word(8'h0B, 1'b0, 1'b0);
        send_word(8'h0C, 1'b0, 1'b0);
        send_word(8'h0A, 1'b0, 1'b0);
        send_word(8'h0D, 1'b0, 1'b0);       // marker at 5 after a repeat
        send_word(8'h55, 1'b1, 1'b0);       // restart mid-stream
        send_word(8'h56, 1'b0, 1'b0);
        send_word(8'h57, 1'b0, 1'b0);
        send_word(8'h58, 1'b0, 1'b1);       // marker on the last word
        set_window(5'd0);                   // zero acts as one
        send_word(8'h33, 1'b1, 1'b0);
        send_word(8'h44, 1'b0, 1'b1);

        // random streams over a spread of window settings
        random_phase(5'd1, 140, 1'b1);      // at most one report per stream; receiver holds off
        random_phase(5'd16, 140, 1'b0);
        random_phase(5'd17, 140, 1'b0);
        random_phase(5'd31, 140, 1'b0);
        quiet = 1'b1;
        random_phase(5'd8, 160, 1'b0);
        quiet = 1'b0;
        random_phase(5'd14, 140, 1'b0);
        random_phase(5'd2, 140, 1'b0);
        random_phase(5'd0, 120, 1'b0);
        for (int p = 0; p < 5; p++)
            random_phase(CFG_W'($urandom_range(0, 31)), 120, 1'b0);
        set_window(WINDOW_RESET);

        drain();
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/dwmd_pkg.sv
src/dwmd_last_seen.sv
src/distinct_window_marker_detector_top.sv
dv/testbench.sv
